### design/serial_controller_registers_top_macros.svh
`ifndef SERIAL_CONTROLLER_REGISTERS_TOP_MACROS_SVH
`define SERIAL_CONTROLLER_REGISTERS_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SCR_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SCR_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

### design/scr_pkg.sv
package scr_pkg;

  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_RX    = 2'd2;

  localparam logic CHAN_A = 1'b1;
  localparam logic CHAN_B = 1'b0;

  localparam logic [3:0] REG_CMD       = 4'd0;
  localparam logic [3:0] REG_INT_MODE  = 4'd1;
  localparam logic [3:0] REG_VECTOR    = 4'd2;
  localparam logic [3:0] REG_IP        = 4'd3;
  localparam logic [3:0] REG_DATA      = 4'd8;
  localparam logic [3:0] REG_MASTER_IC = 4'd9;

  localparam logic [2:0] CMD_POINT_HIGH = 3'd1;

  localparam logic [7:0] RR0_FIXED  = 8'h6C;
  localparam logic [7:0] RR1_FIXED  = 8'h01;
  localparam logic [7:0] RR3_RX_IP  = 8'h04;
  localparam logic [2:0] VEC_STATUS = 3'b010;

  typedef struct packed {
    logic [1:0] func;
    logic       chan;
    logic [3:0] reg_addr;
    logic [7:0] data_in;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_irq;
    logic [7:0] irq_vector;
  } result_t;

  // Receive interrupt on channel B: master enable, a byte waiting, and a
  // receive interrupt mode selected.
  function automatic logic rx_irq_f(input logic [7:0] wr9, input logic [7:0] wr1,
                                    input logic pending);
    return wr9[3] && pending && (wr1[4:3] != 2'b00);
  endfunction

  // Status is folded into the high or low nibble depending on WR9 bit 4.
  function automatic logic [7:0] vector_f(input logic [7:0] wr2, input logic [7:0] wr9,
                                          input logic irq);
    logic [7:0] v;
    v = wr2;
    if (irq) begin
      if (wr9[4]) begin
        v[6:4] = VEC_STATUS;
      end else begin
        v[3:1] = VEC_STATUS;
      end
    end
    return v;
  endfunction

endpackage

### design/scr_if.sv
interface scr_in_if;
  logic          valid;
  logic          ready;
  scr_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scr_out_if;
  logic            valid;
  logic            ready;
  scr_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/serial_controller_registers_top.sv
// Register file of a two-channel serial controller with the console on channel B. Each
// word on req is a register read, a register write or a byte received on channel B; each
// produces exactly one result word on rsp, carrying the read value, any byte sent by a
// channel B WR8 write, and the channel B receive interrupt and modified vector as they stand
// after that word. The block takes one word per clock while req is ready, and the result
// is registered on its way to rsp; the whole register update and result decode are
// combinational between the register file and the result register. A one-word skid stage
// behind the result register keeps req ready for one more word when rsp stalls. Synchronous
// reset clears all write registers, pointers and receive flags; no clearing pass is needed.
`include "serial_controller_registers_top_macros.svh"

module serial_controller_registers_top (
  input  logic          clk,
  input  logic          rst,
  scr_in_if.sink        req,
  scr_out_if.source     rsp
);

  logic [7:0] write_regs [32];
  logic [3:0] reg_pointer [2];
  logic       rx_pending [2];
  logic [7:0] rx_byte [2];

  logic             out_valid;
  scr_pkg::result_t out_data;
  logic             skid_valid;
  scr_pkg::result_t skid_data;

  logic             accept;
  logic             pop;
  scr_pkg::item_t   item;
  logic [3:0]       ptr;
  logic [3:0]       r;
  logic             is_read;
  logic             is_write;
  logic             is_rx;
  logic             do_store;
  logic             shared_reg;
  logic             ptr_load;
  logic [3:0]       ptr_new;
  logic [7:0]       wreg_sel;
  logic             irq_cur;
  logic [7:0]       vec_cur;
  logic [7:0]       b1_next;
  logic [7:0]       b2_next;
  logic [7:0]       b9_next;
  logic             pend_b_next;
  logic             irq_next;
  scr_pkg::result_t res;

  assign item      = req.data;
  assign req.ready = !skid_valid;
  assign accept    = req.valid && req.ready;
  assign pop       = out_valid && rsp.ready;

  assign is_read  = (item.func == scr_pkg::FUNC_READ);
  assign is_write = (item.func == scr_pkg::FUNC_WRITE);
  assign is_rx    = (item.func == scr_pkg::FUNC_RX);

  // A nonzero pointer overrides the address lines for one access.
  assign ptr = reg_pointer[item.chan];
  assign r   = (ptr != 4'd0) ? ptr : item.reg_addr;

  assign wreg_sel = write_regs[{item.chan, r}];
  assign irq_cur  = scr_pkg::rx_irq_f(write_regs[{scr_pkg::CHAN_B, scr_pkg::REG_MASTER_IC}],
                                      write_regs[{scr_pkg::CHAN_B, scr_pkg::REG_INT_MODE}],
                                      rx_pending[scr_pkg::CHAN_B]);
  assign vec_cur  = scr_pkg::vector_f(write_regs[{scr_pkg::CHAN_B, scr_pkg::REG_VECTOR}],
                                      write_regs[{scr_pkg::CHAN_B, scr_pkg::REG_MASTER_IC}],
                                      irq_cur);

  assign do_store   = is_write && (r != scr_pkg::REG_CMD) && (r != scr_pkg::REG_DATA);
  assign shared_reg = (r == scr_pkg::REG_VECTOR) || (r == scr_pkg::REG_MASTER_IC);
  assign ptr_load   = is_write && (r == scr_pkg::REG_CMD);
  assign ptr_new    = {item.data_in[5:3] == scr_pkg::CMD_POINT_HIGH, item.data_in[2:0]};

  // Channel B state as it will stand after this word, for the interrupt outputs.
  assign b1_next = (do_store && item.chan == scr_pkg::CHAN_B && r == scr_pkg::REG_INT_MODE)
                   ? item.data_in : write_regs[{scr_pkg::CHAN_B, scr_pkg::REG_INT_MODE}];
  assign b2_next = (do_store && r == scr_pkg::REG_VECTOR)
                   ? item.data_in : write_regs[{scr_pkg::CHAN_B, scr_pkg::REG_VECTOR}];
  assign b9_next = (do_store && r == scr_pkg::REG_MASTER_IC)
                   ? item.data_in : write_regs[{scr_pkg::CHAN_B, scr_pkg::REG_MASTER_IC}];

  always_comb begin
    pend_b_next = rx_pending[scr_pkg::CHAN_B];
    if (is_rx) begin
      pend_b_next = 1'b1;
    end else if (is_read && item.chan == scr_pkg::CHAN_B && r == scr_pkg::REG_DATA) begin
      pend_b_next = 1'b0;
    end
  end

  assign irq_next = scr_pkg::rx_irq_f(b9_next, b1_next, pend_b_next);

  always_comb begin
    res            = '0;
    res.rx_irq     = irq_next;
    res.irq_vector = scr_pkg::vector_f(b2_next, b9_next, irq_next);
    if (is_read) begin
      unique case (r)
        scr_pkg::REG_CMD:      res.read_data = scr_pkg::RR0_FIXED |
                                               {7'd0, rx_pending[item.chan]};
        scr_pkg::REG_INT_MODE: res.read_data = scr_pkg::RR1_FIXED;
        scr_pkg::REG_VECTOR:   res.read_data = (item.chan == scr_pkg::CHAN_B) ? vec_cur
                                               : wreg_sel;
        scr_pkg::REG_IP:       res.read_data = (item.chan == scr_pkg::CHAN_A && irq_cur)
                                               ? scr_pkg::RR3_RX_IP : 8'd0;
        scr_pkg::REG_DATA:     res.read_data = rx_byte[item.chan];
        default:               res.read_data = wreg_sel;
      endcase
    end else if (is_write && r == scr_pkg::REG_DATA && item.chan == scr_pkg::CHAN_B) begin
      res.tx_valid = 1'b1;
      res.tx_byte  = item.data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) begin
        write_regs[i] <= '0;
      end
      for (int i = 0; i < 2; i++) begin
        reg_pointer[i] <= '0;
        rx_pending[i]  <= 1'b0;
        rx_byte[i]     <= '0;
      end
    end else if (accept) begin
      if (is_read || is_write) begin
        reg_pointer[item.chan] <= ptr_load ? ptr_new : 4'd0;
      end
      if (do_store) begin
        // The vector and master interrupt control registers are common to both channels.
        if (shared_reg) begin
          write_regs[{scr_pkg::CHAN_A, r}] <= item.data_in;
          write_regs[{scr_pkg::CHAN_B, r}] <= item.data_in;
        end else begin
          write_regs[{item.chan, r}] <= item.data_in;
        end
      end
      if (is_read && r == scr_pkg::REG_DATA) begin
        rx_pending[item.chan] <= 1'b0;
      end
      if (is_rx) begin
        rx_byte[scr_pkg::CHAN_B]    <= item.data_in;
        rx_pending[scr_pkg::CHAN_B] <= 1'b1;
      end
    end
  end

  // Result register with one skid word behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else begin
        out_data <= res;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  `SCR_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid word without result word")
  `SCR_ASSERT_NEXT(a_stall_fills_skid, accept && out_valid && !rsp.ready, skid_valid,
                   "stalled result lost a word")
  `SCR_ASSERT_NEXT(a_rx_sets_pending, accept && is_rx, rx_pending[scr_pkg::CHAN_B],
                   "received byte did not set receive-available")

endmodule
